// ===== hw/rtl/bracket_pair_matcher_defines.svh =====
// ---------------------------------------------------------------------------
// Bracket pair matcher assertion macros
// Shared property forms for the checker of the bracket pair matcher.
// ---------------------------------------------------------------------------
`ifndef BRACKET_PAIR_MATCHER_DEFINES_SVH
`define BRACKET_PAIR_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while the disable term is high.
`define BPM_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("bracket_pair_matcher: check failed");

// Next-cycle implication, disabled while the disable term is high.
`define BPM_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("bracket_pair_matcher: check failed");

`endif

// ===== hw/rtl/bpm_pkg.sv =====
// ---------------------------------------------------------------------------
// Bracket pair matcher package
// Sizes, character codes, entry kinds and shared types.
// ---------------------------------------------------------------------------
package bpm_pkg;

  // Stack and position sizing.
  localparam int STACK_DEPTH   = 1024;
  localparam int POSITION_BITS = 16;
  localparam int PLACE_BITS    = 16;
  localparam int ADDR_BITS     = $clog2(STACK_DEPTH);
  localparam int COUNT_BITS    = $clog2(STACK_DEPTH + 1);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Character codes.
  localparam logic [7:0] CHAR_SQ_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CHAR_SQ_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] CHAR_RD_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CHAR_RD_CLOSE = 8'h29;  // ')'

  // Kinds of stack entry.
  typedef enum logic [1:0] {
    KIND_SQUARE  = 2'd0,
    KIND_ROUND   = 2'd1,
    KIND_BARRIER = 2'd2
  } kind_t;

  // One stack entry.
  typedef struct packed {
    kind_t                 kind;
    logic [PLACE_BITS-1:0] place;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // One result item.
  typedef struct packed {
    logic [PLACE_BITS-1:0] position;
    logic                  matched;
    logic [PLACE_BITS-1:0] partner;
    logic                  overflow;
  } result_t;

endpackage

// ===== hw/rtl/bpm_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/bracket_pair_matcher.sv =====
// ---------------------------------------------------------------------------
// Bracket pair matcher
// Stack-based pairing of brackets over a character stream.
// ---------------------------------------------------------------------------
// The block takes one character per transfer and returns one result per
// character from a registered output stage. It sustains one character per
// clock while the skid entry is empty: the top of the stack lives in
// registers, the entry below it is read from the stack RAM every cycle at the
// address that the next stack count selects, and a value written to the RAM in
// the same cycle is forwarded instead of read. A two-entry output stage lets
// the input side keep moving while one result waits. Reset needs no clearing
// pass over the stack RAM, since only entries below the stack count are read.
module bracket_pair_matcher
  import bpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tuser,   // [0] restart
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] position, [31:16] partner_position
  output logic [1:0]  m_tuser    // [0] matched, [1] overflow
);

  logic [COUNT_BITS-1:0]    count, count_next, eff_count, rd_count;
  logic [POSITION_BITS-1:0] next_pos, here;
  entry_t                   top, top_next, second, fwd_data, push_data;
  logic                     fwd_valid;
  logic [ENTRY_BITS-1:0]    rd_data;
  logic [ADDR_BITS-1:0]     rd_addr, wr_addr;
  logic                     wr_en;

  logic       accept;
  logic [7:0] symbol;
  logic       restart;
  logic       is_open, nonempty, full, hit, want_push, do_push, do_pop;
  result_t    res_new, out_res, skid_res;
  logic       out_valid, skid_valid, load_out;

  assign symbol  = s_tdata;
  assign restart = s_tuser;
  assign accept  = s_tvalid && s_tready;

  // Decode the character against the cached top of stack.
  always_comb begin
    eff_count = restart ? '0 : count;
    here      = restart ? '0 : next_pos;
    is_open   = (symbol == CHAR_SQ_OPEN) || (symbol == CHAR_RD_OPEN);
    nonempty  = (eff_count != '0);
    full      = (eff_count == COUNT_BITS'(STACK_DEPTH));
    hit       = nonempty && !is_open &&
                (((top.kind == KIND_SQUARE) && (symbol == CHAR_SQ_CLOSE)) ||
                 ((top.kind == KIND_ROUND)  && (symbol == CHAR_RD_CLOSE)));
    want_push = is_open || (nonempty && !hit);
    do_push   = want_push && !full;
    do_pop    = hit;

    push_data.kind  = (symbol == CHAR_SQ_OPEN) ? KIND_SQUARE :
                      (symbol == CHAR_RD_OPEN) ? KIND_ROUND : KIND_BARRIER;
    push_data.place = is_open ? PLACE_BITS'(here) : '0;
  end

  // The entry below the top: forwarded if it was written last cycle.
  assign second = fwd_valid ? fwd_data : entry_t'(rd_data);

  // Next stack count and top of stack.
  always_comb begin
    priority if (do_push) begin
      count_next = eff_count + COUNT_BITS'(1);
      top_next   = push_data;
    end else if (do_pop) begin
      count_next = eff_count - COUNT_BITS'(1);
      top_next   = second;
    end else begin
      count_next = eff_count;
      top_next   = top;
    end
  end

  // A push spills the old top into the RAM; the read follows the new count.
  assign wr_en    = accept && do_push && nonempty;
  assign wr_addr  = ADDR_BITS'(eff_count - COUNT_BITS'(1));
  assign rd_count = accept ? count_next : count;
  assign rd_addr  = ADDR_BITS'(rd_count - COUNT_BITS'(2));

  bpm_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stack control state and position counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      next_pos  <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
      if (accept) begin
        count    <= count_next;
        next_pos <= (here < POS_MAX) ? here + POSITION_BITS'(1) : POS_MAX;
      end
    end
  end

  // Cached top and forwarded RAM data.
  always_ff @(posedge clk) begin
    fwd_data <= top;
    if (accept) begin
      top <= top_next;
    end
  end

  // Result of the current character.
  always_comb begin
    res_new.position = PLACE_BITS'(here);
    res_new.matched  = do_pop;
    res_new.partner  = do_pop ? top.place : '0;
    res_new.overflow = want_push && full;
  end

  // Output register with a skid entry behind it.
  assign load_out = !out_valid || m_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= skid_valid ? skid_res : res_new;
    end else if (accept) begin
      skid_res <= res_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.partner, out_res.position};
  assign m_tuser  = {out_res.overflow, out_res.matched};

endmodule

// ===== hw/rtl/bpm_checker.sv =====
// ---------------------------------------------------------------------------
// Bracket pair matcher checker
// Port-level properties of the matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "bracket_pair_matcher_defines.svh"

module bpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result holds its contents.
  `BPM_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // A character cannot both close a pair and drop a push.
  `BPM_ASSERT_IMP(a_excl, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))

  // The partner field is zero whenever nothing was matched.
  `BPM_ASSERT_IMP(a_partner, clk, rst, m_tvalid && !m_tuser[0], m_tdata[31:16] == 16'd0)

  // The input side stalls only while a result is waiting.
  `BPM_ASSERT_IMP(a_ready, clk, rst, !s_tready, m_tvalid && !$past(m_tready))

  // Reset leaves no result pending.
  `BPM_ASSERT_NXT(a_reset, clk, 1'b0, rst, !m_tvalid && s_tready)

endmodule

bind bracket_pair_matcher bpm_checker u_bpm_checker (.*);

// ===== bench/tb_bracket_pair_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bracket pair matcher testbench
// Streams character strings into the matcher and checks every result against
// a behavioral stack predictor kept in the bench. The input and result sides
// idle and stall at random in several phases. A short directed string comes
// first. Random strings with mostly well-formed nesting follow.
// ---------------------------------------------------------------------------
module tb_bracket_pair_matcher;
  import bpm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
  } char_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] symbol
  logic        s_tuser = 1'b0;    // [0] restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [15:0] position, [31:16] partner_position
  logic [1:0]  m_tuser;           // [0] matched, [1] overflow

  // Stimulus and expected results.
  char_item_t  char_queue[$];
  result_t     pending_results[$];
  int unsigned chars_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          char_taken = 1'b0;

  // Predictor state: bracket stack and position counter.
  kind_t                    stk_kind[STACK_DEPTH];
  logic [PLACE_BITS-1:0]    stk_place[STACK_DEPTH];
  int unsigned              stk_depth = 0;
  logic [POSITION_BITS-1:0] pos_next = '0;

  bracket_pair_matcher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Push an entry on the predicted stack; returns 1 when the stack is full.
  function automatic bit push_entry(kind_t kind, logic [PLACE_BITS-1:0] place);
    if (stk_depth >= STACK_DEPTH) return 1'b1;
    stk_kind[stk_depth]  = kind;
    stk_place[stk_depth] = place;
    stk_depth++;
    return 1'b0;
  endfunction

  // Work out the result of one character and advance the predicted state.
  function automatic result_t match_symbol(logic [7:0] symbol, logic restart);
    result_t                  res;
    logic [POSITION_BITS-1:0] here;
    kind_t                    top_kind;
    res = '0;
    if (restart) begin
      stk_depth = 0;
      pos_next  = '0;
    end
    here = pos_next;
    if (here != POS_MAX) pos_next = here + 1'b1;
    res.position = here[PLACE_BITS-1:0];
    if (symbol == CHAR_SQ_OPEN) begin
      res.overflow = push_entry(KIND_SQUARE, here[PLACE_BITS-1:0]);
    end else if (symbol == CHAR_RD_OPEN) begin
      res.overflow = push_entry(KIND_ROUND, here[PLACE_BITS-1:0]);
    end else if (stk_depth > 0) begin
      top_kind = stk_kind[stk_depth-1];
      if ((top_kind == KIND_SQUARE && symbol == CHAR_SQ_CLOSE) ||
          (top_kind == KIND_ROUND && symbol == CHAR_RD_CLOSE)) begin
        res.matched = 1'b1;
        res.partner = stk_place[stk_depth-1];
        stk_depth--;
      end else begin
        res.overflow = push_entry(KIND_BARRIER, '0);
      end
    end
    return res;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Input driver: offers the next character at the falling edge.
  always @(negedge clk) begin : drive_chars
    char_item_t nxt;
    if (!rst) begin
      if (!s_tvalid || char_taken) begin
        if (char_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = char_queue.pop_front();
          s_tdata  <= nxt.symbol;
          s_tuser  <= nxt.restart;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      char_taken = 1'b0;
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pending_results.insert(pending_results.size(), match_symbol(s_tdata, s_tuser));
        chars_taken++;
        char_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with none expected, got %h / %b",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("position", want.position, m_tdata[15:0]);
          check_field("matched", want.matched, m_tuser[0]);
          check_field("partner_position", want.partner, m_tdata[31:16]);
          check_field("overflow", want.overflow, m_tuser[1]);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_char(input logic [7:0] symbol, input logic restart);
    char_item_t it;
    it.symbol  = symbol;
    it.restart = restart;
    char_queue.insert(char_queue.size(), it);
    chars_queued++;
  endtask

  // One string of random content that mostly nests properly.
  task automatic add_string(input int unsigned len, input bit fresh);
    logic [7:0]  opened[$];
    logic [7:0]  sym;
    int unsigned pick;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        sym = $urandom_range(0, 1) ? CHAR_SQ_OPEN : CHAR_RD_OPEN;
        opened.insert(opened.size(), sym);
      end else if (pick < 65 && opened.size() > 0) begin
        sym = (opened.pop_back() == CHAR_SQ_OPEN) ? CHAR_SQ_CLOSE : CHAR_RD_CLOSE;
      end else if (pick < 80) begin
        sym = $urandom_range(0, 1) ? CHAR_SQ_CLOSE : CHAR_RD_CLOSE;
      end else begin
        sym = 8'($urandom_range(0, 255));
      end
      add_char(sym, fresh && i == 0);
    end
  endtask

  // Random strings until about the given number of characters is queued.
  task automatic add_random(input int unsigned count);
    int unsigned target;
    target = chars_queued + count;
    while (chars_queued < target)
      add_string($urandom_range(1, 40), $urandom_range(0, 99) < 85);
  endtask

  task automatic drain;
    while (chars_taken != chars_queued || pending_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed string: pairs, closers on an empty stack, barriers, restart.
    add_char(CHAR_SQ_OPEN, 1'b1);
    add_char(CHAR_RD_OPEN, 1'b0);
    add_char(CHAR_RD_CLOSE, 1'b0);
    add_char(CHAR_SQ_CLOSE, 1'b0);
    add_char(CHAR_SQ_CLOSE, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(CHAR_SQ_OPEN, 1'b0);
    add_char(CHAR_RD_CLOSE, 1'b0);
    add_char(CHAR_SQ_CLOSE, 1'b0);
    add_char("X", 1'b0);
    add_char(CHAR_RD_OPEN, 1'b1);
    add_char(CHAR_RD_CLOSE, 1'b0);
    add_char(CHAR_RD_CLOSE, 1'b1);
    add_char(CHAR_RD_OPEN, 1'b0);
    add_char(CHAR_SQ_OPEN, 1'b0);
    add_char(CHAR_SQ_CLOSE, 1'b0);
    add_char(8'hAA, 1'b0);
    add_char(8'h55, 1'b0);
    add_char(CHAR_RD_CLOSE, 1'b0);
    add_char(8'hFF, 1'b1);

    add_random(240);
    drain();

    send_idle_pct = 84;
    add_random(190);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    add_random(190);
    drain();

    send_idle_pct  = 37;
    recv_stall_pct = 37;
    add_random(170);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
